// File: hdl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define ASSERT_CLK_ALWAYS(label, clk_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

// File: hdl/dddp_pkg.sv
package dddp_pkg;

  // fixed field widths
  localparam int CFG_W    = 16;
  localparam int LIMIT_W  = 9;
  localparam int DRIVE_W  = 32;
  localparam int GAIN_FRAC = 12;
  localparam int INTEG_W  = 17;
  localparam int CFG_IDX_W = 3;

  // defaults for the top level parameters
  localparam int INTEGRAL_BAND_DEF  = 3;
  localparam int POSITION_WIDTH_DEF = 24;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LATERAL_KP   = 3'd0,
    CFG_LATERAL_KI   = 3'd1,
    CFG_LATERAL_KD   = 3'd2,
    CFG_DRIFT_GAIN   = 3'd3,
    CFG_TURN_KP      = 3'd4,
    CFG_TURN_KI      = 3'd5,
    CFG_TURN_KD      = 3'd6,
    CFG_INTEGRAL_CAP = 3'd7
  } cfg_idx_t;

  // register values after reset
  localparam logic [CFG_W-1:0] LATERAL_KP_RST   = 16'd287;
  localparam logic [CFG_W-1:0] LATERAL_KI_RST   = 16'd0;
  localparam logic [CFG_W-1:0] LATERAL_KD_RST   = 16'd819;
  localparam logic [CFG_W-1:0] DRIFT_GAIN_RST   = 16'd737;
  localparam logic [CFG_W-1:0] TURN_KP_RST      = 16'd1229;
  localparam logic [CFG_W-1:0] TURN_KI_RST      = 16'd0;
  localparam logic [CFG_W-1:0] TURN_KD_RST      = 16'd0;
  localparam logic [CFG_W-1:0] INTEGRAL_CAP_RST = 16'd300;

endpackage

// File: hdl/differential_drive_dual_pid.sv
// Dual PID controller for a differential drive, one control tick per item.
// Input channel s_*: one item per tick carrying both encoder positions, the
// targets and the power limits in s_tdata, the move mode and clamp direction
// in s_tuser. Output channel m_*: one item per input item with the left and
// right drive powers (signed Q.12 volts, saturated to 32 bits).
// Gains and the integral cap are written through cfg_we / cfg_index /
// cfg_data, by the user only while no item is in flight; the block does not
// enforce this. Gains are unsigned Q4.12. From input accept to output valid
// the item moves from the input register through the error and integral
// stage, the multiplier stage and the sum and clamp stage into the output
// register. Throughput: one item per cycle when not stalled; the loop state
// (previous errors and integrals) is updated in a single stage so consecutive
// items chain. Reset (synchronous, rst high) empties the pipeline, clears the
// loop state and loads the default gains. When the receiver holds m_tready
// low the output item stays put, stages behind it keep filling bubbles, and
// s_tready drops only once every stage holds an item.
module differential_drive_dual_pid #(
  parameter int INTEGRAL_BAND  = dddp_pkg::INTEGRAL_BAND_DEF,
  parameter int POSITION_WIDTH = dddp_pkg::POSITION_WIDTH_DEF,
  localparam int IN_W = ((4 * POSITION_WIDTH + 2 * dddp_pkg::LIMIT_W + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [dddp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dddp_pkg::CFG_W-1:0]      cfg_data,
  // input items
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // left_position, right_position, lateral_target, turn_target,
  // lateral_limit, turn_limit, zero padding
  input  logic [IN_W-1:0]                 s_tdata,
  // move_mode, clamp_direction
  input  logic [1:0]                      s_tuser,
  // result items
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // left_drive, right_drive
  output logic [2*dddp_pkg::DRIVE_W-1:0]  m_tdata
);

  localparam int P       = POSITION_WIDTH;
  localparam int LW      = dddp_pkg::LIMIT_W;
  localparam int DW      = dddp_pkg::DRIVE_W;
  localparam int IW      = dddp_pkg::INTEG_W;
  localparam int GW      = dddp_pkg::CFG_W + 1;
  localparam int ERR_W   = P + 1;
  localparam int TERR_W  = P + 2;
  localparam int DER_W   = P + 3;
  localparam int ISUM_W  = ((P + 2 > IW) ? P + 2 : IW) + 1;
  localparam int PROD_W  = ((DER_W + GW > 2 * IW) ? DER_W + GW : 2 * IW);
  localparam int PWR_W   = PROD_W + 2;
  localparam int OUT_W   = PWR_W + 1;
  localparam logic signed [ERR_W-1:0] BAND_P = ERR_W'(INTEGRAL_BAND);
  localparam logic signed [ERR_W-1:0] BAND_N = -BAND_P;

  // configuration registers
  logic [dddp_pkg::CFG_W-1:0] lateral_kp, lateral_ki, lateral_kd, drift_gain;
  logic [dddp_pkg::CFG_W-1:0] turn_kp, turn_ki, turn_kd, integral_cap;

  always_ff @(posedge clk) begin
    if (rst) begin
      lateral_kp   <= dddp_pkg::LATERAL_KP_RST;
      lateral_ki   <= dddp_pkg::LATERAL_KI_RST;
      lateral_kd   <= dddp_pkg::LATERAL_KD_RST;
      drift_gain   <= dddp_pkg::DRIFT_GAIN_RST;
      turn_kp      <= dddp_pkg::TURN_KP_RST;
      turn_ki      <= dddp_pkg::TURN_KI_RST;
      turn_kd      <= dddp_pkg::TURN_KD_RST;
      integral_cap <= dddp_pkg::INTEGRAL_CAP_RST;
    end else if (cfg_we) begin
      unique case (dddp_pkg::cfg_idx_t'(cfg_index))
        dddp_pkg::CFG_LATERAL_KP:   lateral_kp   <= cfg_data;
        dddp_pkg::CFG_LATERAL_KI:   lateral_ki   <= cfg_data;
        dddp_pkg::CFG_LATERAL_KD:   lateral_kd   <= cfg_data;
        dddp_pkg::CFG_DRIFT_GAIN:   drift_gain   <= cfg_data;
        dddp_pkg::CFG_TURN_KP:      turn_kp      <= cfg_data;
        dddp_pkg::CFG_TURN_KI:      turn_ki      <= cfg_data;
        dddp_pkg::CFG_TURN_KD:      turn_kd      <= cfg_data;
        dddp_pkg::CFG_INTEGRAL_CAP: integral_cap <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline valids and stage enables
  logic v0, v1, v2, v3, v4;
  logic en0, en1, en2, en3, en4;

  assign en4 = !v4 || m_tready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign en0 = !v0 || en1;
  assign s_tready = en0;
  assign m_tvalid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en0) v0 <= s_tvalid;
      if (en1) v1 <= v0;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // stage 0: input register
  logic signed [P-1:0]  s0_left, s0_right, s0_lat_tgt, s0_trn_tgt;
  logic signed [LW-1:0] s0_lat_lim, s0_trn_lim;
  logic                 s0_pivot, s0_below;

  always_ff @(posedge clk) begin
    if (en0) begin
      s0_left    <= s_tdata[P-1:0];
      s0_right   <= s_tdata[2*P-1:P];
      s0_lat_tgt <= s_tdata[3*P-1:2*P];
      s0_trn_tgt <= s_tdata[4*P-1:3*P];
      s0_lat_lim <= s_tdata[4*P+LW-1:4*P];
      s0_trn_lim <= s_tdata[4*P+2*LW-1:4*P+LW];
      s0_pivot   <= s_tuser[0];
      s0_below   <= s_tuser[1];
    end
  end

  // loop state
  logic signed [TERR_W-1:0] last_lateral_error, last_turn_error;
  logic signed [IW-1:0]     lateral_integral, turn_integral;

  // stage 1 logic: errors, derivatives, integral update with band and cap
  logic signed [ERR_W-1:0]  err, diff;
  logic signed [TERR_W-1:0] terr;
  logic signed [DER_W-1:0]  lderiv, tderiv;
  logic signed [ISUM_W-1:0] lsum, tsum, cap_p, cap_n;
  logic signed [IW-1:0]     lateral_integral_next, turn_integral_next;
  logic                     lat_gate, trn_gate;

  always_comb begin
    err    = ERR_W'(s0_lat_tgt) - ERR_W'(s0_left);
    diff   = ERR_W'(s0_left) - ERR_W'(s0_right);
    terr   = TERR_W'(s0_trn_tgt) - TERR_W'(diff);
    lderiv = DER_W'(err) - DER_W'(last_lateral_error);
    tderiv = DER_W'(terr) - DER_W'(last_turn_error);
    lat_gate = (err > BAND_P) || (err < BAND_N);
    trn_gate = (err < BAND_P) && (err > BAND_N);
    cap_p  = $signed(ISUM_W'(integral_cap));
    cap_n  = -cap_p;
    lsum   = lat_gate ? (ISUM_W'(lateral_integral) + ISUM_W'(err)) : '0;
    tsum   = trn_gate ? (ISUM_W'(turn_integral) + ISUM_W'(terr)) : '0;
    // cap both accumulators to plus or minus the limit
    if (lsum > cap_p)      lateral_integral_next = IW'(cap_p);
    else if (lsum < cap_n) lateral_integral_next = IW'(cap_n);
    else                   lateral_integral_next = IW'(lsum);
    if (tsum > cap_p)      turn_integral_next = IW'(cap_p);
    else if (tsum < cap_n) turn_integral_next = IW'(cap_n);
    else                   turn_integral_next = IW'(tsum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_lateral_error <= '0;
      last_turn_error    <= '0;
      lateral_integral   <= '0;
      turn_integral      <= '0;
    end else if (en1 && v0) begin
      last_lateral_error <= TERR_W'(err);
      last_turn_error    <= terr;
      lateral_integral   <= lateral_integral_next;
      turn_integral      <= turn_integral_next;
    end
  end

  // stage 1 register
  logic signed [ERR_W-1:0]  s1_err, s1_diff;
  logic signed [TERR_W-1:0] s1_terr;
  logic signed [DER_W-1:0]  s1_lderiv, s1_tderiv;
  logic signed [IW-1:0]     s1_linteg, s1_tinteg;
  logic signed [LW-1:0]     s1_lat_lim, s1_trn_lim;
  logic                     s1_pivot, s1_below;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_err     <= err;
      s1_diff    <= diff;
      s1_terr    <= terr;
      s1_lderiv  <= lderiv;
      s1_tderiv  <= tderiv;
      s1_linteg  <= lateral_integral_next;
      s1_tinteg  <= turn_integral_next;
      s1_lat_lim <= s0_lat_lim;
      s1_trn_lim <= s0_trn_lim;
      s1_pivot   <= s0_pivot;
      s1_below   <= s0_below;
    end
  end

  // stage 2: independent gain products
  logic signed [PROD_W-1:0] s2_lp, s2_li, s2_ld, s2_tp, s2_ti, s2_td, s2_drift;
  logic signed [LW-1:0]     s2_lat_lim, s2_trn_lim;
  logic                     s2_pivot, s2_below;

  function automatic logic signed [PROD_W-1:0] gain_ext(input logic [dddp_pkg::CFG_W-1:0] g);
    gain_ext = $signed(PROD_W'(g));
  endfunction

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_lp      <= PROD_W'(s1_err)    * gain_ext(lateral_kp);
      s2_li      <= PROD_W'(s1_linteg) * gain_ext(lateral_ki);
      s2_ld      <= PROD_W'(s1_lderiv) * gain_ext(lateral_kd);
      s2_tp      <= PROD_W'(s1_terr)   * gain_ext(turn_kp);
      s2_ti      <= PROD_W'(s1_tinteg) * gain_ext(turn_ki);
      s2_td      <= PROD_W'(s1_tderiv) * gain_ext(turn_kd);
      s2_drift   <= PROD_W'(s1_diff)   * gain_ext(drift_gain);
      s2_lat_lim <= s1_lat_lim;
      s2_trn_lim <= s1_trn_lim;
      s2_pivot   <= s1_pivot;
      s2_below   <= s1_below;
    end
  end

  // stage 3 logic: sum the terms and clamp one side to the limit
  logic signed [PWR_W-1:0] lat_sum, trn_sum, lat_lv, trn_lv, lat_pwr, trn_pwr;

  always_comb begin
    lat_sum = PWR_W'(s2_lp) + PWR_W'(s2_li) + PWR_W'(s2_ld);
    trn_sum = PWR_W'(s2_tp) + PWR_W'(s2_ti) + PWR_W'(s2_td);
    lat_lv  = PWR_W'($signed({s2_lat_lim, {dddp_pkg::GAIN_FRAC{1'b0}}}));
    trn_lv  = PWR_W'($signed({s2_trn_lim, {dddp_pkg::GAIN_FRAC{1'b0}}}));
    if (s2_below) begin
      lat_pwr = (lat_sum < lat_lv) ? lat_lv : lat_sum;
      trn_pwr = (trn_sum < trn_lv) ? trn_lv : trn_sum;
    end else begin
      lat_pwr = (lat_sum > lat_lv) ? lat_lv : lat_sum;
      trn_pwr = (trn_sum > trn_lv) ? trn_lv : trn_sum;
    end
  end

  logic signed [PWR_W-1:0]  s3_lat_pwr, s3_trn_pwr;
  logic signed [PROD_W-1:0] s3_drift;
  logic                     s3_pivot;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_lat_pwr <= lat_pwr;
      s3_trn_pwr <= trn_pwr;
      s3_drift   <= s2_drift;
      s3_pivot   <= s2_pivot;
    end
  end

  // stage 4 logic: drive mix and saturation to 32 bits
  function automatic logic [DW-1:0] sat_drive(input logic signed [OUT_W-1:0] v);
    logic [OUT_W-DW:0] hi;
    hi = v[OUT_W-1:DW-1];
    if ((&hi) || !(|hi)) sat_drive = v[DW-1:0];
    else if (v[OUT_W-1]) sat_drive = {1'b1, {(DW-1){1'b0}}};
    else                 sat_drive = {1'b0, {(DW-1){1'b1}}};
  endfunction

  logic signed [OUT_W-1:0] left_mix, right_mix;

  always_comb begin
    if (s3_pivot) begin
      left_mix  = OUT_W'(s3_trn_pwr);
      right_mix = -OUT_W'(s3_trn_pwr);
    end else begin
      left_mix  = OUT_W'(s3_lat_pwr) - OUT_W'(s3_drift);
      right_mix = OUT_W'(s3_lat_pwr) + OUT_W'(s3_drift);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en4) begin
      m_tdata <= {sat_drive(right_mix), sat_drive(left_mix)};
    end
  end

endmodule

// File: hdl/dddp_checker.sv
`include "assert_macros.svh"

module dddp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [2*dddp_pkg::DRIVE_W-1:0] m_tdata
);

  // reset empties the pipeline
  `ASSERT_CLK_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid, "result item valid after reset")

  // with the output free every stage moves, so input is taken
  `ASSERT_CLK(a_ready_when_free, clk, rst, (!m_tvalid || m_tready) |-> s_tready, "input stalled while output free")

  // a held result item keeps its value
  `ASSERT_CLK(a_hold_stalled, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result item changed")

  // an input item can only be refused while a result waits
  `ASSERT_CLK(a_stall_cause, clk, rst, (s_tvalid && !s_tready) |-> (m_tvalid && !m_tready), "input refused without output stall")

endmodule

bind differential_drive_dual_pid dddp_checker u_dddp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
